// ===== rtl/core/rai_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_pkg
// Shared types, constants and helpers of the route angle interpolator.
// ----------------------------------------------------------------------------
package rai_pkg;

  localparam int CENTER_LIMIT = 9000;
  localparam int NODE_COUNT   = 5;
  localparam int NODE_W       = 64;
  localparam int LAP_W        = 31;
  localparam int HW_W         = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 64;

  // divider of front and back: 50-bit dividend, 33-bit divisor, one quotient bit a step
  localparam int DVD_W     = 50;
  localparam int DVS_W     = 33;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int ACC_W = 20;

  localparam logic [14:0]  Q15_ONE  = 15'd32767;
  localparam logic [16:0]  SMOOTH_3 = 17'd98301;
  localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(CENTER_LIMIT);
  localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE0    = 3'd0,
    CFG_NODE1    = 3'd1,
    CFG_NODE2    = 3'd2,
    CFG_NODE3    = 3'd3,
    CFG_NODE4    = 3'd4,
    CFG_LAP      = 3'd5,
    CFG_HALF_WIN = 3'd6,
    CFG_ROUTE_EN = 3'd7
  } cfg_idx_t;

  typedef logic [NODE_COUNT-1:0][NODE_W-1:0] node_arr_t;

  typedef struct packed {
    logic signed [31:0] travel_distance;
    logic signed [15:0] yaw_measured;
    logic signed [15:0] pitch_measured;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] wrapped_distance;
    logic [1:0]         segment_index;
    logic signed [15:0] yaw_center;
    logic signed [15:0] pitch_center;
    logic               active_flag;
    logic signed [15:0] yaw_error;
    logic signed [15:0] pitch_error;
  } out_item_t;

  // classified request passed from front to back
  typedef struct packed {
    in_item_t           item;
    logic signed [31:0] wrap_dist;
    logic [1:0]         seg;
    logic               found;
    logic [32:0]        num;
    logic [32:0]        den;
  } job_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_WRAP,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [3:0] {
    BE_IDLE,
    BE_LOAD,
    BE_Q_DIV,
    BE_S_MUL1,
    BE_S_MUL2,
    BE_S_DIV,
    BE_S_DIV2,
    BE_N_MUL,
    BE_N_DIV,
    BE_AX_MUL,
    BE_AX_GO,
    BE_AX_DIV,
    BE_FIN
  } be_state_t;

  function automatic logic signed [31:0] node_dist(input logic [NODE_W-1:0] w);
    return $signed(w[31:0]);
  endfunction

  function automatic logic signed [15:0] node_yaw(input logic [NODE_W-1:0] w);
    return $signed(w[47:32]);
  endfunction

  function automatic logic signed [15:0] node_pitch(input logic [NODE_W-1:0] w);
    return $signed(w[63:48]);
  endfunction

  function automatic logic signed [15:0] clamp_lim(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > LIM_POS) begin
      r = LIM_POS;
    end else if (v < LIM_NEG) begin
      r = LIM_NEG;
    end else begin
      r = v;
    end
    return r[15:0];
  endfunction

  // error beyond the dead band; magnitude of the half window taken wide
  function automatic logic signed [15:0] win_err(input logic signed [15:0] center,
                                                 input logic signed [15:0] pos,
                                                 input logic signed [15:0] hw);
    logic signed [ACC_W-1:0] diff;
    logic signed [ACC_W-1:0] mag;
    logic signed [15:0]      r;
    diff = ACC_W'(center) - ACC_W'(pos);
    mag  = hw[15] ? -ACC_W'(hw) : ACC_W'(hw);
    if (diff > mag) begin
      r = clamp_lim(diff - mag);
    end else if (diff < -mag) begin
      r = clamp_lim(diff + mag);
    end else begin
      r = '0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/rai_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rai_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rai_pkg::DVD_W-1:0]  dividend,
  input  logic [rai_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [rai_pkg::DVD_W-1:0]  quotient,
  output logic [rai_pkg::DVS_W-1:0]  remainder
);

  logic                          run;
  logic [rai_pkg::DIV_CNT_W-1:0] cnt;
  logic [rai_pkg::DVS_W-1:0]     dvs;
  logic [rai_pkg::DVS_W:0]       rem_sh;
  logic                          fits;

  assign rem_sh = {remainder, quotient[rai_pkg::DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == rai_pkg::DIV_CNT_W'(rai_pkg::DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dvs       <= divisor;
    end else if (run) begin
      remainder <= fits ? rai_pkg::DVS_W'(rem_sh - {1'b0, dvs})
                        : rem_sh[rai_pkg::DVS_W-1:0];
      quotient  <= {quotient[rai_pkg::DVD_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/rai_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_queue
// Two-entry queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module rai_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rai_pkg::job_t job_in,
  input  logic          pop,
  output rai_pkg::job_t job_out,
  output logic          empty,
  output logic          full
);

  rai_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign job_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

endmodule

// ===== rtl/core/rai_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_front
// Accept a request, wrap the distance by the lap and find its segment.
// ----------------------------------------------------------------------------
module rai_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  rai_pkg::in_item_t            item,
  input  rai_pkg::node_arr_t           nodes,
  input  logic [rai_pkg::LAP_W-1:0]    lap_length,
  input  logic                         q_full,
  output logic                         busy,
  output logic                         push,
  output rai_pkg::job_t                job
);

  rai_pkg::fe_state_t state, state_next;
  rai_pkg::in_item_t  cur;
  logic signed [31:0] wrap_dist;
  logic               neg;

  logic                        div_start;
  logic [rai_pkg::DVD_W-1:0]   div_dvd;
  logic                        div_done;
  logic [rai_pkg::DVD_W-1:0]   div_quo;
  logic [rai_pkg::DVS_W-1:0]   div_rem;
  logic [31:0]                 mag;
  logic [rai_pkg::LAP_W-1:0]   rem;

  assign mag     = item.travel_distance[31] ? (~item.travel_distance + 32'd1)
                                            : item.travel_distance;
  assign div_dvd = rai_pkg::DVD_W'(mag);
  assign rem     = div_rem[rai_pkg::LAP_W-1:0];

  rai_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (rai_pkg::DVS_W'(lap_length)),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rai_pkg::FE_IDLE: begin
        if (start) begin
          state_next = (lap_length == '0) ? rai_pkg::FE_PUSH : rai_pkg::FE_WRAP;
        end
      end
      rai_pkg::FE_WRAP: begin
        if (div_done) begin
          state_next = rai_pkg::FE_PUSH;
        end
      end
      rai_pkg::FE_PUSH: begin
        if (!q_full) begin
          state_next = rai_pkg::FE_IDLE;
        end
      end
      default: state_next = rai_pkg::FE_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != rai_pkg::FE_IDLE);
    div_start = (state == rai_pkg::FE_IDLE) && start && (lap_length != '0);
    push      = (state == rai_pkg::FE_PUSH) && !q_full;
  end

  // first segment that holds the distance wins
  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    job.item      = cur;
    job.wrap_dist = wrap_dist;
    job.seg       = 2'd3;
    job.found     = 1'b0;
    job.num       = '0;
    job.den       = '0;
    for (int i = 3; i >= 0; i--) begin
      a = rai_pkg::node_dist(nodes[i]);
      b = rai_pkg::node_dist(nodes[i+1]);
      if (wrap_dist >= a && wrap_dist < b) begin
        job.seg   = 2'(i);
        job.found = 1'b1;
        job.num   = 33'({wrap_dist[31], wrap_dist} - {a[31], a});
        job.den   = 33'({b[31], b} - {a[31], a});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rai_pkg::FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rai_pkg::FE_IDLE && start) begin
      cur       <= item;
      wrap_dist <= item.travel_distance;
      neg       <= item.travel_distance[31];
    end else if (state == rai_pkg::FE_WRAP && div_done) begin
      // fold a negative remainder back into the lap
      wrap_dist <= (neg && rem != '0) ? $signed(32'(lap_length - rem))
                                      : $signed(32'(rem));
    end
  end

endmodule

// ===== rtl/core/rai_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rai_back
// Ease, interpolate and clamp the centres, then form the window errors.
// ----------------------------------------------------------------------------
module rai_back (
  input  logic                       clk,
  input  logic                       rst,
  input  rai_pkg::job_t              job,
  input  logic                       q_empty,
  input  rai_pkg::node_arr_t         nodes,
  input  logic [rai_pkg::HW_W-1:0]   half_windows,
  input  logic                       route_enabled,
  output logic                       pop,
  output logic                       done,
  output rai_pkg::out_item_t         result
);

  rai_pkg::be_state_t state, state_next;
  rai_pkg::job_t      cur;
  logic [32:0]        num_r;
  logic [14:0]        qv;
  logic [29:0]        sq;
  logic [16:0]        tv;
  logic signed [50:0] prod;
  logic               sgn;
  logic               axis;
  logic signed [rai_pkg::ACC_W-1:0] yc_raw;
  logic signed [rai_pkg::ACC_W-1:0] pc_raw;

  logic                        div_start;
  logic [rai_pkg::DVD_W-1:0]   div_dvd;
  logic [rai_pkg::DVS_W-1:0]   div_dvs;
  logic                        div_done;
  logic [rai_pkg::DVD_W-1:0]   div_quo;
  logic [rai_pkg::DVS_W-1:0]   div_rem;

  // divide by 32767 by folding the high part onto the low part
  logic [47:0]                 mx;
  logic [33:0]                 mq;
  logic [32:0]                 m_hi;
  logic [14:0]                 m_lo;
  logic                        m_fin;
  logic [47:0]                 mx_fold;
  logic [33:0]                 mq_fold;

  logic                        eased;
  logic [2:0]                  seg_hi;
  logic signed [15:0]          ang_a;
  logic signed [15:0]          ang_b;
  logic signed [16:0]          dy;
  logic signed [50:0]          sum;
  logic [50:0]                 sum_mag;
  logic [46:0]                 stp;
  logic [47:0]                 sdp;
  logic signed [rai_pkg::ACC_W-1:0] qs;
  logic signed [15:0]          yc;
  logic signed [15:0]          pc;

  assign eased   = (cur.seg == 2'd1) || (cur.seg == 2'd3);
  assign seg_hi  = {1'b0, cur.seg} + 3'd1;
  assign ang_a   = axis ? rai_pkg::node_pitch(nodes[cur.seg])
                        : rai_pkg::node_yaw(nodes[cur.seg]);
  assign ang_b   = axis ? rai_pkg::node_pitch(nodes[seg_hi])
                        : rai_pkg::node_yaw(nodes[seg_hi]);
  assign dy      = 17'(ang_b) - 17'(ang_a);
  assign sum     = prod + $signed({19'b0, cur.den[32:1]});
  assign sum_mag = sum[50] ? 51'(-sum) : 51'(sum);
  assign stp     = 47'(sq) * 47'(tv);
  assign sdp     = 48'(qv) * 48'(cur.den);
  assign qs      = sgn ? -$signed(rai_pkg::ACC_W'(div_quo[18:0]))
                       : $signed(rai_pkg::ACC_W'(div_quo[18:0]));
  assign yc      = rai_pkg::clamp_lim(yc_raw);
  assign pc      = rai_pkg::clamp_lim(pc_raw);

  assign m_hi  = mx[47:15];
  assign m_lo  = mx[14:0];
  assign m_fin = (m_hi == '0) && (m_lo != rai_pkg::Q15_ONE);

  always_comb begin
    if (m_hi != '0) begin
      mx_fold = 48'(m_hi) + 48'(m_lo);
      mq_fold = mq + 34'(m_hi);
    end else begin
      mx_fold = '0;
      mq_fold = mq + 34'd1;
    end
  end

  rai_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      rai_pkg::BE_IDLE:   if (!q_empty) state_next = rai_pkg::BE_LOAD;
      rai_pkg::BE_LOAD: begin
        priority if (!cur.found) begin
          state_next = rai_pkg::BE_FIN;
        end else if (eased) begin
          state_next = rai_pkg::BE_Q_DIV;
        end else begin
          state_next = rai_pkg::BE_AX_MUL;
        end
      end
      rai_pkg::BE_Q_DIV:  if (div_done) state_next = rai_pkg::BE_S_MUL1;
      rai_pkg::BE_S_MUL1: state_next = rai_pkg::BE_S_MUL2;
      rai_pkg::BE_S_MUL2: state_next = rai_pkg::BE_S_DIV;
      rai_pkg::BE_S_DIV:  if (m_fin) state_next = rai_pkg::BE_S_DIV2;
      rai_pkg::BE_S_DIV2: if (m_fin) state_next = rai_pkg::BE_N_MUL;
      rai_pkg::BE_N_MUL:  state_next = rai_pkg::BE_N_DIV;
      rai_pkg::BE_N_DIV:  if (m_fin) state_next = rai_pkg::BE_AX_MUL;
      rai_pkg::BE_AX_MUL: state_next = rai_pkg::BE_AX_GO;
      rai_pkg::BE_AX_GO:  state_next = rai_pkg::BE_AX_DIV;
      rai_pkg::BE_AX_DIV: begin
        if (div_done) begin
          state_next = axis ? rai_pkg::BE_FIN : rai_pkg::BE_AX_MUL;
        end
      end
      rai_pkg::BE_FIN:    state_next = rai_pkg::BE_IDLE;
      default:            state_next = rai_pkg::BE_IDLE;
    endcase
  end

  always_comb begin
    pop       = (state == rai_pkg::BE_IDLE) && !q_empty;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = cur.den;
    unique case (state)
      rai_pkg::BE_LOAD: begin
        div_start = cur.found && eased;
        div_dvd   = (rai_pkg::DVD_W'(cur.num) << 15) - rai_pkg::DVD_W'(cur.num);
      end
      rai_pkg::BE_AX_GO: begin
        div_start = 1'b1;
        div_dvd   = sum_mag[rai_pkg::DVD_W-1:0];
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rai_pkg::BE_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == rai_pkg::BE_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rai_pkg::BE_IDLE: begin
        cur  <= job;
        axis <= 1'b0;
      end
      rai_pkg::BE_LOAD: begin
        num_r  <= cur.num;
        // fall back on the final node
        yc_raw <= rai_pkg::ACC_W'(rai_pkg::node_yaw(nodes[4]));
        pc_raw <= rai_pkg::ACC_W'(rai_pkg::node_pitch(nodes[4]));
      end
      rai_pkg::BE_Q_DIV:  if (div_done) qv <= div_quo[14:0];
      rai_pkg::BE_S_MUL1: begin
        sq <= 30'(qv) * 30'(qv);
        tv <= rai_pkg::SMOOTH_3 - {1'b0, qv, 1'b0};
      end
      rai_pkg::BE_S_MUL2: begin
        mx <= 48'(stp);
        mq <= '0;
      end
      // divide by 32767 twice to divide by its square
      rai_pkg::BE_S_DIV: begin
        if (m_fin) begin
          mx <= 48'(mq);
          mq <= '0;
        end else begin
          mx <= mx_fold;
          mq <= mq_fold;
        end
      end
      rai_pkg::BE_S_DIV2: begin
        if (m_fin) begin
          qv <= mq[14:0];
        end else begin
          mx <= mx_fold;
          mq <= mq_fold;
        end
      end
      rai_pkg::BE_N_MUL: begin
        mx <= sdp;
        mq <= '0;
      end
      rai_pkg::BE_N_DIV: begin
        if (m_fin) begin
          num_r <= mq[32:0];
        end else begin
          mx <= mx_fold;
          mq <= mq_fold;
        end
      end
      rai_pkg::BE_AX_MUL: prod <= dy * $signed({1'b0, num_r});
      rai_pkg::BE_AX_GO:  sgn <= sum[50];
      rai_pkg::BE_AX_DIV: begin
        if (div_done) begin
          if (axis) begin
            pc_raw <= rai_pkg::ACC_W'(ang_a) + qs;
          end else begin
            yc_raw <= rai_pkg::ACC_W'(ang_a) + qs;
          end
          axis <= 1'b1;
        end
      end
      rai_pkg::BE_FIN: begin
        result.wrapped_distance <= cur.wrap_dist;
        result.segment_index    <= cur.seg;
        result.yaw_center       <= yc;
        result.pitch_center     <= pc;
        result.active_flag      <= route_enabled;
        result.yaw_error        <= route_enabled
          ? rai_pkg::win_err(yc, cur.item.yaw_measured, $signed(half_windows[15:0]))
          : '0;
        result.pitch_error      <= route_enabled
          ? rai_pkg::win_err(pc, cur.item.pitch_measured, $signed(half_windows[31:16]))
          : '0;
      end
      default: begin
        sgn <= sgn;
      end
    endcase
  end

endmodule

// ===== rtl/core/route_angle_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_angle_interpolator
// Route centre interpolation with smoothstep easing and dead-band errors.
// ----------------------------------------------------------------------------
// Flow: the front runs its divider for the lap wrap only when the lap length is
//   nonzero; the back goes straight to the result on fallback, runs one
//   50-step divide per axis on segments 0 and 2, and on segments 1 and 3
//   adds a 50-step Q15 fraction divide and short fold loops for /32767.
// Throughput: one request per back-end pass; the two-entry queue lets the
//   front take new requests while the back is still working.
// Reset: rst clears control state and config only; nothing waits on reset.
// The receiver cannot stall: each result shows for one cycle with done high.
// ----------------------------------------------------------------------------
module route_angle_interpolator (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  rai_pkg::in_item_t                 item,
  // result channel
  output logic                              done,
  output rai_pkg::out_item_t                result,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rai_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rai_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rai_pkg::node_arr_t            nodes;
  logic [rai_pkg::LAP_W-1:0]     lap_length;
  logic [rai_pkg::HW_W-1:0]      half_windows;
  logic                          route_enabled;

  logic          fe_busy;
  logic          q_push;
  logic          q_pop;
  logic          q_empty;
  logic          q_full;
  rai_pkg::job_t fe_job;
  rai_pkg::job_t be_job;

  // configuration is always taken at once
  assign cfg_ready = 1'b1;
  assign busy      = fe_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes         <= '0;
      lap_length    <= '0;
      half_windows  <= '0;
      route_enabled <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rai_pkg::cfg_idx_t'(cfg_index))
        rai_pkg::CFG_NODE0:    nodes[0]      <= cfg_data;
        rai_pkg::CFG_NODE1:    nodes[1]      <= cfg_data;
        rai_pkg::CFG_NODE2:    nodes[2]      <= cfg_data;
        rai_pkg::CFG_NODE3:    nodes[3]      <= cfg_data;
        rai_pkg::CFG_NODE4:    nodes[4]      <= cfg_data;
        rai_pkg::CFG_LAP:      lap_length    <= cfg_data[rai_pkg::LAP_W-1:0];
        rai_pkg::CFG_HALF_WIN: half_windows  <= cfg_data[rai_pkg::HW_W-1:0];
        rai_pkg::CFG_ROUTE_EN: route_enabled <= cfg_data[0];
        default:               route_enabled <= route_enabled;
      endcase
    end
  end

  // front: take the request, wrap the distance, classify the segment
  rai_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .nodes      (nodes),
    .lap_length (lap_length),
    .q_full     (q_full),
    .busy       (fe_busy),
    .push       (q_push),
    .job        (fe_job)
  );

  // hold classified requests so front and back stall independently
  rai_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (fe_job),
    .pop     (q_pop),
    .job_out (be_job),
    .empty   (q_empty),
    .full    (q_full)
  );

  // back: ease, interpolate, clamp, and form the window errors
  rai_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (be_job),
    .q_empty       (q_empty),
    .nodes         (nodes),
    .half_windows  (half_windows),
    .route_enabled (route_enabled),
    .pop           (q_pop),
    .done          (done),
    .result        (result)
  );

endmodule
